// ===== rtl/core/lcs_pkg.sv =====
// shared types and constants for the lcs length engine
// no dependencies; imported by every module of the engine
package lcs_pkg;

  localparam int unsigned MaxLenDefault = 64;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned OpW           = 2;
  localparam int unsigned SymW          = 8;
  localparam int unsigned LenOutW       = 7;
  localparam int unsigned LenOutMax     = 127;

  // operation codes on the input channel (code 3 has no meaning)
  typedef enum logic [OpW-1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_COMPUTE       = 2'd2
  } op_e;

  // command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_WRITE_FIRST  = 2'd0,
    CMD_WRITE_SECOND = 2'd1,
    CMD_COMPUTE      = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [SymW-1:0]   symbol;
  } cmd_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
  } queue_status_t;

endpackage

// ===== rtl/core/lcs_front.sv =====
// front end: accepts input beats, decodes the operation and queues a command
// depends on lcs_pkg
module lcs_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [lcs_pkg::OpW-1:0]  operation_i,
  input  logic [lcs_pkg::SymW-1:0] symbol_i,
  input  lcs_pkg::queue_status_t   q_status_i,
  output logic                  push_o,
  output lcs_pkg::cmd_t         cmd_o
);
  import lcs_pkg::*;

  logic accept;
  logic known_op;
  logic [31:0] beat_cnt_q, beat_cnt_d;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;

  always_comb begin
    known_op    = 1'b1;
    cmd_o.kind   = CMD_COMPUTE;
    cmd_o.symbol = symbol_i;
    unique case (op_e'(operation_i))
      OP_APPEND_FIRST:  cmd_o.kind = CMD_WRITE_FIRST;
      OP_APPEND_SECOND: cmd_o.kind = CMD_WRITE_SECOND;
      OP_COMPUTE:       cmd_o.kind = CMD_COMPUTE;
      default:          known_op   = 1'b0;
    endcase
  end

  // unused operation codes are consumed and dropped here
  assign push_o = accept && known_op;

  // running count of accepted beats, handy when probing the block
  assign beat_cnt_d = accept ? beat_cnt_q + 32'd1 : beat_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_cnt_q <= '0;
    end else begin
      beat_cnt_q <= beat_cnt_d;
    end
  end

endmodule

// ===== rtl/core/lcs_queue.sv =====
// short command queue between front and back
// depends on lcs_pkg
module lcs_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lcs_pkg::cmd_t         cmd_i,
  output lcs_pkg::queue_status_t status_o,
  output logic                  valid_o,
  output lcs_pkg::cmd_t         cmd_o,
  input  logic                  pop_i
);
  import lcs_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign valid_o       = (count_q != '0);
  assign status_o.full = (count_q == CntW'(QueueDepth));
  assign cmd_o         = slot_q[rd_ptr_q];
  assign do_push       = push_i && !status_o.full;
  assign do_pop        = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/core/lcs_back.sv =====
// back end: string stores, score row memory, row-by-row table fill, result register
// depends on lcs_pkg
module lcs_back #(
  parameter int unsigned MaxLen = lcs_pkg::MaxLenDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  lcs_pkg::cmd_t             q_cmd_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [lcs_pkg::LenOutW-1:0] lcs_length_o,
  output logic                      overflow_o
);
  import lcs_pkg::*;

  localparam int unsigned AddrW  = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned LenW   = $clog2(MaxLen + 1);
  localparam int unsigned ScoreW = LenW;
  localparam int unsigned ExtW   = ScoreW + LenOutW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ROW  = 4'b0010,
    S_CELL = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [LenW-1:0]   len_a_q, len_a_d;
  logic [LenW-1:0]   len_b_q, len_b_d;
  logic              drop_q, drop_d;
  logic [AddrW-1:0]  row_q, row_d;
  logic [AddrW-1:0]  col_q, col_d;
  logic              first_row_q, first_row_d;
  logic [ScoreW-1:0] left_q, left_d;
  logic [ScoreW-1:0] diag_q, diag_d;
  logic [ScoreW-1:0] result_q, result_d;
  logic              out_valid_q, out_valid_d;
  logic [LenOutW-1:0] out_len_q, out_len_d;
  logic              out_ovf_q, out_ovf_d;

  // memories
  logic [SymW-1:0]   mem_a [MaxLen];
  logic [SymW-1:0]   mem_b [MaxLen];
  logic [ScoreW-1:0] mem_s [MaxLen];
  logic [SymW-1:0]   a_rd_q, b_rd_q;
  logic [ScoreW-1:0] s_rd_q;

  logic              wr_a, wr_b, wr_s;
  logic [AddrW-1:0]  rd_col;
  logic [ScoreW-1:0] up, cell_val;
  logic              last_col, last_row;
  logic              out_free;
  logic [ExtW-1:0]   res_ext;

  assign pop_o       = (state_q == S_IDLE) && q_valid_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign lcs_length_o = out_len_q;
  assign overflow_o  = out_ovf_q;

  // one table cell: diagonal plus one on a match, else the larger neighbour
  assign up       = first_row_q ? '0 : s_rd_q;
  assign cell_val = (a_rd_q == b_rd_q) ? diag_q + ScoreW'(1)
                                       : ((up > left_q) ? up : left_q);
  assign last_col = (LenW'(col_q) + LenW'(1)) == len_b_q;
  assign last_row = (LenW'(row_q) + LenW'(1)) == len_a_q;
  assign rd_col   = (state_q == S_CELL) ? col_q + AddrW'(1) : '0;
  assign res_ext  = {{LenOutW{1'b0}}, result_q};

  always_comb begin
    state_d     = state_q;
    len_a_d     = len_a_q;
    len_b_d     = len_b_q;
    drop_d      = drop_q;
    row_d       = row_q;
    col_d       = col_q;
    first_row_d = first_row_q;
    left_d      = left_q;
    diag_d      = diag_q;
    result_d    = result_q;
    out_len_d   = out_len_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_a        = 1'b0;
    wr_b        = 1'b0;
    wr_s        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          unique case (q_cmd_i.kind)
            CMD_WRITE_FIRST: begin
              if (len_a_q < LenW'(MaxLen)) begin
                wr_a    = 1'b1;
                len_a_d = len_a_q + LenW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            CMD_WRITE_SECOND: begin
              if (len_b_q < LenW'(MaxLen)) begin
                wr_b    = 1'b1;
                len_b_d = len_b_q + LenW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            CMD_COMPUTE: begin
              result_d    = '0;
              row_d       = '0;
              first_row_d = 1'b1;
              if (len_a_q == '0 || len_b_q == '0) begin
                state_d = S_FIN;
              end else begin
                state_d = S_ROW;
              end
            end
            default: ;
          endcase
        end
      end
      S_ROW: begin
        col_d   = '0;
        left_d  = '0;
        diag_d  = '0;
        state_d = S_CELL;
      end
      S_CELL: begin
        wr_s   = 1'b1;
        left_d = cell_val;
        diag_d = up;
        col_d  = col_q + AddrW'(1);
        if (last_col) begin
          result_d    = cell_val;
          first_row_d = 1'b0;
          if (last_row) begin
            state_d = S_FIN;
          end else begin
            row_d   = row_q + AddrW'(1);
            state_d = S_ROW;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_len_d   = (res_ext > ExtW'(LenOutMax)) ? LenOutW'(LenOutMax)
                                                     : res_ext[LenOutW-1:0];
          out_ovf_d   = drop_q;
          len_a_d     = '0;
          len_b_d     = '0;
          drop_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_a_q     <= '0;
      len_b_q     <= '0;
      drop_q      <= 1'b0;
      first_row_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_a_q     <= len_a_d;
      len_b_q     <= len_b_d;
      drop_q      <= drop_d;
      first_row_q <= first_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    col_q     <= col_d;
    left_q    <= left_d;
    diag_q    <= diag_d;
    result_q  <= result_d;
    out_len_q <= out_len_d;
    out_ovf_q <= out_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[len_a_q[AddrW-1:0]] <= q_cmd_i.symbol;
    end
    a_rd_q <= mem_a[row_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[len_b_q[AddrW-1:0]] <= q_cmd_i.symbol;
    end
    b_rd_q <= mem_b[rd_col];
  end

  always_ff @(posedge clk_i) begin
    if (wr_s) begin
      mem_s[col_q] <= cell_val;
    end
    s_rd_q <= mem_s[rd_col];
  end

endmodule

// ===== rtl/core/lcs_length_engine_top.sv =====
// top level of the lcs length engine: front, command queue and back
// depends on lcs_pkg, lcs_front, lcs_queue, lcs_back
//
//  channel | beat carries              | handshake
//  --------+---------------------------+---------------------------
//  in      | operation_i, symbol_i     | in_valid_i / in_stall_o
//  out     | lcs_length_o, overflow_o  | out_valid_o / out_stall_i
//
// an append beat is taken every cycle while the queue has room and is written
// to its string store as the back end pops it; a compute beat fills the table
// one row at a time through the score row memory, one cell per cycle, so it
// occupies the back end until the table is filled and its result is registered
// no clearing pass after reset: the string stores hold nothing until written
// and the first table row reads as zero
// the result register lets the front keep queueing beats while out is stalled
module lcs_length_engine_top #(
  parameter int unsigned MaxLen = lcs_pkg::MaxLenDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lcs_pkg::OpW-1:0]     operation_i,
  input  logic [lcs_pkg::SymW-1:0]    symbol_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lcs_pkg::LenOutW-1:0] lcs_length_o,
  output logic                        overflow_o
);
  import lcs_pkg::*;

  // front to queue
  logic          push;
  cmd_t          push_cmd;
  queue_status_t q_status;
  // queue to back
  logic          q_valid;
  cmd_t          q_cmd;
  logic          pop;

  // decode of the operation, unused codes dropped here
  lcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .symbol_i    (symbol_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // decouples intake from the table fill
  lcs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .status_o (q_status),
    .valid_o  (q_valid),
    .cmd_o    (q_cmd),
    .pop_i    (pop)
  );

  // string stores, table fill and the result register
  lcs_back #(
    .MaxLen (MaxLen)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .lcs_length_o (lcs_length_o),
    .overflow_o   (overflow_o)
  );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the lcs length engine, top module testbench
// depends on lcs_pkg and lcs_length_engine_top; predicts each result with its own lcs table
module testbench;
  import lcs_pkg::*;

  localparam int unsigned MaxLen           = MaxLenDefault;
  // an unused op code, which the engine should swallow without a result
  localparam logic [OpW-1:0] OpUnused      = 2'd3;
  localparam int unsigned RandomBeats      = 550;
  localparam int unsigned RandomComputes   = 40;
  // tail wait at the end, longer than the longest compute takes to fill its table
  localparam int unsigned TailCycles       = MaxLen * (MaxLen + 1) + 16;
  localparam int unsigned HoldAfterResults = 12;
  localparam int unsigned HoldCycles       = 400;
  localparam int unsigned CycleLimit       = 1_000_000;
  localparam int unsigned ReportLimit      = 10;

  // one queued input beat, or a marker that makes the sender wait for all results
  typedef struct packed {
    logic            drain;
    logic [OpW-1:0]  op;
    logic [SymW-1:0] sym;
  } pending_beat_t;

  typedef struct packed {
    logic [LenOutW-1:0] len;
    logic               ovf;
  } lcs_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_e;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [OpW-1:0]     operation_i  = '0;
  logic [SymW-1:0]    symbol_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [LenOutW-1:0] lcs_length_o;
  logic               overflow_o;

  lcs_length_engine_top #(
    .MaxLen(MaxLen)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .symbol_i    (symbol_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .lcs_length_o(lcs_length_o),
    .overflow_o  (overflow_o)
  );

  // beats still to be offered, and results the engine still owes us
  pending_beat_t pending_beats[$];
  lcs_result_t   awaited_results[$];

  // our own copy of the engine state
  logic [SymW-1:0] first_syms  [MaxLen];
  logic [SymW-1:0] second_syms [MaxLen];
  int unsigned     first_count  = 0;
  int unsigned     second_count = 0;
  logic            dropped_seen = 1'b0;

  int unsigned error_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned cycle_count   = 0;
  logic        in_beat_taken = 1'b0;

  // stimulus generation bookkeeping
  int unsigned     beats_queued    = 0;
  int unsigned     computes_queued = 0;
  logic [SymW-1:0] alphabet [4];
  int unsigned     alphabet_size   = 0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // classic lcs table, kept as a single row that is overwritten left to right
  function automatic logic [LenOutW-1:0] lcs_of_stored();
    int unsigned row [MaxLen+1];
    int unsigned diag;
    int unsigned up;
    int unsigned cell_val;
    for (int j = 0; j <= MaxLen; j++) row[j] = 0;
    for (int i = 0; i < first_count; i++) begin
      diag = 0;
      for (int j = 1; j <= second_count; j++) begin
        up = row[j];
        if (first_syms[i] == second_syms[j-1]) cell_val = diag + 1;
        else cell_val = (up > row[j-1]) ? up : row[j-1];
        diag   = up;
        row[j] = cell_val;
      end
    end
    // saturation only bites with a store longer than the result field allows
    if (row[second_count] > LenOutMax) return LenOutW'(LenOutMax);
    return LenOutW'(row[second_count]);
  endfunction

  // update our copy of the state for one accepted beat
  function automatic void apply_engine_beat(logic [OpW-1:0] op, logic [SymW-1:0] sym);
    lcs_result_t res;
    case (op)
      OP_APPEND_FIRST: begin
        if (first_count < MaxLen) begin
          first_syms[first_count] = sym;
          first_count++;
        end else begin
          dropped_seen = 1'b1;
        end
      end
      OP_APPEND_SECOND: begin
        if (second_count < MaxLen) begin
          second_syms[second_count] = sym;
          second_count++;
        end else begin
          dropped_seen = 1'b1;
        end
      end
      OP_COMPUTE: begin
        res.len = lcs_of_stored();
        res.ovf = dropped_seen;
        awaited_results.push_back(res);
        first_count  = 0;
        second_count = 0;
        dropped_seen = 1'b0;
      end
      default: ;  // unused code: no state change, no result
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset and run limit
  // ---------------------------------------------------------------------------

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still awaited",
             cycle_count, awaited_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sender: bursts of beats with random gaps, honouring drain markers
  // ---------------------------------------------------------------------------

  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : drive_in
    pending_beat_t next_beat;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_beat_taken) begin
      // beat still stalled: hold valid and payload
    end else if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending_beats.size() == 0 ||
                 (pending_beats[0].drain && awaited_results.size() != 0)) begin
      in_valid_i <= 1'b0;
    end else begin
      next_beat = pending_beats.pop_front();
      if (next_beat.drain) begin
        in_valid_i <= 1'b0;
      end else begin
        operation_i <= next_beat.op;
        symbol_i    <= next_beat.sym;
        in_valid_i  <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          // now and then a long run with no idling at all
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(40, 120);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern in phases, plus one long hold-off to back the engine up
  // ---------------------------------------------------------------------------

  stall_mode_e stall_mode  = STALL_NONE;
  int unsigned stall_phase = 0;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (!hold_done && results_seen >= HoldAfterResults) begin
      // long hold: queue and result register fill, so in_stall_o must rise
      out_stall_i <= 1'b1;
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end else begin
      if (stall_phase == 0) begin
        stall_mode  = stall_mode_e'($urandom_range(0, 2));
        stall_phase = $urandom_range(16, 96);
      end else begin
        stall_phase = stall_phase - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        default:     out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: results are checked before the same edge's input beat is predicted,
  // so a result can never be matched against an expectation from this very edge
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : watch
    lcs_result_t want;
    in_beat_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen = results_seen + 1;
      if (awaited_results.size() == 0) begin
        error_count = error_count + 1;
        if (error_count <= ReportLimit)
          $display("unexpected result: length %0d overflow %0b", lcs_length_o, overflow_o);
      end else begin
        want = awaited_results.pop_front();
        if (want.len !== lcs_length_o || want.ovf !== overflow_o) begin
          error_count = error_count + 1;
          if (error_count <= ReportLimit)
            $display("result %0d mismatch: length exp %0d got %0d, overflow exp %0b got %0b",
                     results_seen, want.len, lcs_length_o, want.ovf, overflow_o);
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) apply_engine_beat(operation_i, symbol_i);
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic void queue_beat(logic [OpW-1:0] op, logic [SymW-1:0] sym);
    pending_beat_t b;
    b.drain = 1'b0;
    b.op    = op;
    b.sym   = sym;
    pending_beats.push_back(b);
    if (op != OpUnused) beats_queued++;
    if (op == OP_COMPUTE) computes_queued++;
  endfunction

  function automatic void queue_drain();
    pending_beat_t b;
    b       = '0;
    b.drain = 1'b1;
    pending_beats.push_back(b);
  endfunction

  // a small alphabet gives plenty of matches, size zero means any byte
  function automatic logic [SymW-1:0] pick_symbol();
    if (alphabet_size == 0) return SymW'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, alphabet_size - 1)];
  endfunction

  // one pair of strings with interleaved appends, usually closed by a compute
  function automatic void add_string_pair();
    int unsigned n_first;
    int unsigned n_second;
    int unsigned size_pick;
    size_pick = $urandom_range(0, 99);
    if (size_pick < 80) begin
      n_first  = $urandom_range(0, 10);
      n_second = $urandom_range(0, 10);
    end else if (size_pick < 94) begin
      n_first  = $urandom_range(0, 40);
      n_second = $urandom_range(0, 40);
    end else begin
      // near or past the store size, often overflowing one side
      n_first  = $urandom_range(MaxLen - 6, MaxLen + 6);
      n_second = $urandom_range(MaxLen - 6, MaxLen + 6);
    end
    if ($urandom_range(0, 3) == 0) begin
      alphabet_size = 0;
    end else begin
      alphabet_size = $urandom_range(1, 4);
      for (int k = 0; k < 4; k++) alphabet[k] = SymW'($urandom_range(0, 255));
    end
    while (n_first + n_second > 0) begin
      if ($urandom_range(0, 19) == 0) queue_beat(OpUnused, SymW'($urandom_range(0, 255)));
      if (n_second == 0 || (n_first > 0 && $urandom_range(0, 1) == 0)) begin
        queue_beat(OP_APPEND_FIRST, pick_symbol());
        n_first--;
      end else begin
        queue_beat(OP_APPEND_SECOND, pick_symbol());
        n_second--;
      end
    end
    // a pair left without a compute runs on into the next one
    if ($urandom_range(0, 11) != 0) queue_beat(OP_COMPUTE, SymW'($urandom_range(0, 255)));
  endfunction

  initial begin : run
    logic [SymW-1:0] sym;
    logic            mid_drain_done;
    mid_drain_done = 1'b0;

    // directed: empty strings, the unused code, one-sided strings, byte extremes
    queue_beat(OP_COMPUTE, 8'hff);
    queue_beat(OpUnused, 8'hff);
    queue_beat(OP_COMPUTE, 8'h00);
    queue_beat(OP_APPEND_FIRST, 8'h00);
    queue_beat(OP_COMPUTE, 8'h00);
    queue_beat(OP_APPEND_SECOND, 8'hff);
    queue_beat(OP_COMPUTE, 8'h00);
    queue_beat(OP_APPEND_FIRST, 8'hff);
    queue_beat(OpUnused, 8'h00);
    queue_beat(OP_APPEND_SECOND, 8'hff);
    queue_beat(OP_COMPUTE, 8'h5a);
    queue_beat(OP_APPEND_FIRST, 8'h00);
    queue_beat(OP_APPEND_SECOND, 8'hff);
    queue_beat(OP_COMPUTE, 8'ha5);
    // crossed pair: only one of the two symbols can line up
    queue_beat(OP_APPEND_FIRST, 8'haa);
    queue_beat(OP_APPEND_FIRST, 8'h55);
    queue_beat(OP_APPEND_SECOND, 8'h55);
    queue_beat(OP_APPEND_SECOND, 8'haa);
    queue_beat(OP_COMPUTE, 8'h00);
    queue_drain();

    // both stores full with the same bytes and two more dropped on each side
    beats_queued    = 0;
    computes_queued = 0;
    for (int k = 0; k < MaxLen + 2; k++) begin
      sym = SymW'($urandom_range(0, 255));
      queue_beat(OP_APPEND_FIRST, sym);
      queue_beat(OP_APPEND_SECOND, sym);
    end
    queue_beat(OP_COMPUTE, 8'h00);

    // random pairs until enough beats and results are lined up
    while (beats_queued < RandomBeats || computes_queued < RandomComputes) begin
      add_string_pair();
      if (!mid_drain_done && beats_queued >= RandomBeats / 2) begin
        queue_drain();
        mid_drain_done = 1'b1;
      end
    end
    queue_beat(OP_COMPUTE, 8'h00);

    while (pending_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    error_count = error_count + awaited_results.size();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lcs_pkg.sv
rtl/core/lcs_front.sv
rtl/core/lcs_queue.sv
rtl/core/lcs_back.sv
rtl/core/lcs_length_engine_top.sv
tb/testbench.sv
